/* design/phnd_pkg.sv */
`default_nettype none
package phnd_pkg;

    localparam int FifoDepth = 4;
    localparam int PtrW = $clog2(FifoDepth);
    localparam int CntW = $clog2(FifoDepth + 1);

    localparam logic [7:0] CharX    = 8'h78;
    localparam logic [7:0] CharDash = 8'h2d;
    localparam logic [7:0] Char0    = 8'h30;
    localparam logic [7:0] Char9    = 8'h39;
    localparam logic [7:0] CharA    = 8'h61;
    localparam logic [7:0] CharF    = 8'h66;
    localparam logic [7:0] CharZ    = 8'h7a;
    localparam logic [4:0] HexTen   = 5'd10;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
        logic       is_empty;
    } in_item_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] byte_value;
        logic       is_final;
        logic       name_ok;
    } out_item_t;

    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } result_pair_t;

    typedef enum logic [4:0] {
        PH_START = 5'b00001,
        PH_GOT_X = 5'b00010,
        PH_PLAIN = 5'b00100,
        PH_HEX   = 5'b01000,
        PH_BAD   = 5'b10000
    } phase_t;

    function automatic logic is_plain(input logic [7:0] c);
        return (c inside {[Char0:Char9]}) || (c inside {[CharA:CharZ]});
    endfunction

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c inside {[Char0:Char9]})
        begin
            v = 5'(c - Char0);
        end
        else if (c inside {[CharA:CharF]})
        begin
            v = HexTen + 5'(c - CharA);
        end
        return v;
    endfunction

    function automatic out_item_t make_result(input logic has, input logic [7:0] val,
                                              input logic fin, input logic ok);
        out_item_t r;
        r.has_byte   = has;
        r.byte_value = has ? val : 8'd0;
        r.is_final   = fin;
        r.name_ok    = fin ? ok : 1'b0;
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/phnd_core.sv */
`default_nettype none
module phnd_core
    import phnd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire in_item_t     item,
    input  wire logic         advance,
    output result_pair_t      results
);

    phase_t     phase_reg, phase_next;
    logic [3:0] high_nibble_reg, high_nibble_next;
    logic       nibble_pending_reg, nibble_pending_next;
    logic       saw_non_plain_reg, saw_non_plain_next;

    logic [7:0] c;
    logic       last;
    logic [4:0] hv;
    logic [7:0] pair_byte;
    logic       snp;

    assign c         = item.char_code;
    assign last      = item.is_last;
    assign hv        = hex_value(c);
    assign pair_byte = {high_nibble_reg, hv[3:0]};
    assign snp       = saw_non_plain_reg | ~is_plain(pair_byte);

    always_comb
    begin
        results.count        = 2'd0;
        results.first        = make_result(1'b0, 8'd0, 1'b0, 1'b0);
        results.second       = make_result(1'b0, 8'd0, 1'b0, 1'b0);
        phase_next           = phase_reg;
        high_nibble_next     = high_nibble_reg;
        nibble_pending_next  = nibble_pending_reg;
        saw_non_plain_next   = saw_non_plain_reg;
        if (item.is_empty)
        begin
            results.count = 2'd1;
            results.first = make_result(1'b0, 8'd0, 1'b1, 1'b0);
        end
        else
        begin
            case (phase_reg)
                PH_START:
                begin
                    if (c == CharX)
                    begin
                        if (last)
                        begin
                            results.count = 2'd1;
                            results.first = make_result(1'b1, c, 1'b1, 1'b1);
                        end
                        else
                        begin
                            phase_next = PH_GOT_X;
                        end
                    end
                    else if (is_plain(c))
                    begin
                        results.count = 2'd1;
                        results.first = make_result(1'b1, c, last, 1'b1);
                        phase_next    = PH_PLAIN;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_GOT_X:
                begin
                    if (c == CharDash)
                    begin
                        if (last)
                        begin
                            results.count = 2'd1;
                            results.first = make_result(1'b0, 8'd0, 1'b1, 1'b1);
                        end
                        else
                        begin
                            phase_next = PH_HEX;
                        end
                    end
                    else if (is_plain(c))
                    begin
                        results.count  = 2'd2;
                        results.first  = make_result(1'b1, CharX, 1'b0, 1'b0);
                        results.second = make_result(1'b1, c, last, 1'b1);
                        phase_next     = PH_PLAIN;
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_PLAIN:
                begin
                    if (is_plain(c))
                    begin
                        results.count = 2'd1;
                        results.first = make_result(1'b1, c, last, 1'b1);
                    end
                    else
                    begin
                        phase_next = PH_BAD;
                    end
                end
                PH_HEX:
                begin
                    if (hv[4])
                    begin
                        phase_next = PH_BAD;
                    end
                    else if (nibble_pending_reg)
                    begin
                        saw_non_plain_next  = snp;
                        nibble_pending_next = 1'b0;
                        high_nibble_next    = 4'd0;
                        results.count       = 2'd1;
                        results.first       = make_result(1'b1, pair_byte, last, snp);
                    end
                    else
                    begin
                        high_nibble_next    = hv[3:0];
                        nibble_pending_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_BAD;
                end
            endcase
            if (last && (results.count == 2'd0))
            begin
                results.count = 2'd1;
                results.first = make_result(1'b0, 8'd0, 1'b1, 1'b0);
            end
        end
        if (item.is_empty || last)
        begin
            phase_next          = PH_START;
            high_nibble_next    = 4'd0;
            nibble_pending_next = 1'b0;
            saw_non_plain_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_START;
            high_nibble_reg    <= 4'd0;
            nibble_pending_reg <= 1'b0;
            saw_non_plain_reg  <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg          <= phase_next;
            high_nibble_reg    <= high_nibble_next;
            nibble_pending_reg <= nibble_pending_next;
            saw_non_plain_reg  <= saw_non_plain_next;
        end
    end

endmodule
`default_nettype wire

/* design/phnd_fifo.sv */
`default_nettype none
module phnd_fifo
    import phnd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire result_pair_t push,
    input  wire logic         push_en,
    output logic [CntW-1:0]   count,
    output logic              valid,
    input  wire logic         ready,
    output out_item_t         data
);

    out_item_t           mem [FifoDepth];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]     count_reg;
    logic [1:0]          push_n;
    logic                pop;
    logic [PtrW-1:0]     wr_ptr_1;

    assign push_n   = push_en ? push.count : 2'd0;
    assign pop      = valid && ready;
    assign valid    = (count_reg != '0);
    assign count    = count_reg;
    assign data     = mem[rd_ptr_reg];
    assign wr_ptr_1 = wr_ptr_reg + PtrW'(1);

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2)
        begin
            mem[wr_ptr_1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PtrW'(push_n);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PtrW'(1);
            end
            count_reg <= count_reg + CntW'(push_n) - CntW'(pop);
        end
    end

endmodule
`default_nettype wire

/* design/prefixed_hex_name_decoder.sv */
// Prefixed hex name decoder.
// Input channel in_valid/in_ready/in_item carries one character of a name per
// transaction, with is_last marking the final character and is_empty marking a
// zero-length name. Output channel out_valid/out_ready/out_item carries the
// result transactions: tentative bytes, and on the last one of a name the
// verdict in name_ok (discard the name's bytes when it is 0).
// Each accepted character is captured in the input register; its results are
// then written into the result queue, from which the output presents them.
// Throughput: one character per cycle while the result queue has room; a
// character that yields two results (a leading x of a plain name) holds the
// input when the result queue is near full.
// The rate is set by the input register feeding a four-entry result queue that
// takes up to two results per cycle and drains one per cycle when out_ready.
// Reset clears the decode state and empties the input register and the queue.
// When the receiver stalls, results collect in the queue; once the next item's
// results would not fit, in_ready drops and the pending item is held.
`default_nettype none
module prefixed_hex_name_decoder
    import phnd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    logic          s1_valid_reg;
    in_item_t      s1_item_reg;
    result_pair_t  results;
    logic [CntW-1:0] fifo_count;
    logic          advance;

    assign advance  = s1_valid_reg &&
                      ((32'(fifo_count) + 32'(results.count)) <= FifoDepth);
    assign in_ready = !s1_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_item_reg <= in_item;
        end
    end

    phnd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (s1_item_reg),
        .advance (advance),
        .results (results)
    );

    phnd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (results),
        .push_en (advance),
        .count   (fifo_count),
        .valid   (out_valid),
        .ready   (out_ready),
        .data    (out_item)
    );

endmodule
`default_nettype wire
